/* rtl/core/mpow2_pkg.sv */
// Shared types, widths and helpers for the 2x2 matrix power block.
package mpow2_pkg;

   // Field widths fixed by the channel payloads.
   localparam int FIELD_W = 64;
   localparam int EXP_W   = 63;

   // Arithmetic width of the matrix entries (8 to 64).
   localparam int ENTRY_W = 64;

   // Split of an entry into a low and a high half for the partial products.
   localparam int LO_W = (ENTRY_W + 1) / 2;
   localparam int HI_W = ENTRY_W - LO_W;

   // Number of entries in a matrix and of scalar products in a matrix product.
   localparam int N_ENTRY = 4;
   localparam int N_PROD  = 8;

   typedef logic signed [FIELD_W-1:0] field_type;
   typedef logic [EXP_W-1:0]          exp_type;
   typedef logic [ENTRY_W-1:0]        entry_type;

   // Matrix product selection: result times base, or base times base.
   typedef enum logic {
      OP_MUL,
      OP_SQR
   } op_type;

   typedef struct packed {
      logic   load;     // take a new base matrix, reset the result to identity
      logic   issue;    // start a matrix product in the pipeline
      op_type op;       // which product to start
      logic   capture;  // copy the result matrix to the response register
   } dp_cmd_type;

   typedef struct packed {
      logic busy;       // a product is still in flight
   } dp_stat_type;

   // Sign-extend an entry to the width of a response field.
   function automatic field_type sext_entry(entry_type v);
      return FIELD_W'(signed'(v));
   endfunction

endpackage

/* rtl/core/mpow2_if.sv */
// Request and response channel interfaces of the 2x2 matrix power block.
interface mpow2_req_if;
   logic                  valid;
   logic                  ready;
   mpow2_pkg::field_type  m00_in;
   mpow2_pkg::field_type  m01_in;
   mpow2_pkg::field_type  m10_in;
   mpow2_pkg::field_type  m11_in;
   mpow2_pkg::exp_type    exponent;

   modport source (
      output valid, m00_in, m01_in, m10_in, m11_in, exponent,
      input  ready
   );
   modport sink (
      input  valid, m00_in, m01_in, m10_in, m11_in, exponent,
      output ready
   );
endinterface

interface mpow2_rsp_if;
   logic                  valid;
   logic                  ready;
   mpow2_pkg::field_type  r00_out;
   mpow2_pkg::field_type  r01_out;
   mpow2_pkg::field_type  r10_out;
   mpow2_pkg::field_type  r11_out;

   modport source (
      output valid, r00_out, r01_out, r10_out, r11_out,
      input  ready
   );
   modport sink (
      input  valid, r00_out, r01_out, r10_out, r11_out,
      output ready
   );
endinterface

/* rtl/core/matrix_power_2x2.sv */
// Top level of the 2x2 matrix power block: controller, datapath and channel hookup.
// Throughput: one transaction at a time; each exponent bit goes through the shared 3-stage
//   matrix product pipeline, which drains before the next bit is taken.
// Reset: synchronous, active high; clears the controller state and all valid flags.
module matrix_power_2x2 (
   input  logic        clock,
   input  logic        reset,
   mpow2_req_if.sink   req_bus,
   mpow2_rsp_if.source rsp_bus
);

   // Command and status between the controller and the datapath.
   mpow2_pkg::dp_cmd_type  dp_cmd;
   mpow2_pkg::dp_stat_type dp_stat;

   // Controller: accept a request transaction, walk the exponent from the low bit,
   // issue result-times-base on set bits and base squaring while higher bits remain,
   // then hold the result in the response register until it is taken.
   mpow2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .exponent  (req_bus.exponent),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (dp_cmd),
      .stat      (dp_stat)
   );

   // Datapath: hold the result and base matrices, run each matrix product through
   // partial products, scalar products and entry sums, write back the target matrix.
   // The response register frees the controller to take the next request while a
   // finished result still waits on the response channel.
   mpow2_dp u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (dp_cmd),
      .stat    (dp_stat),
      .m00_in  (req_bus.m00_in),
      .m01_in  (req_bus.m01_in),
      .m10_in  (req_bus.m10_in),
      .m11_in  (req_bus.m11_in),
      .r00_out (rsp_bus.r00_out),
      .r01_out (rsp_bus.r01_out),
      .r10_out (rsp_bus.r10_out),
      .r11_out (rsp_bus.r11_out)
   );

endmodule

/* rtl/core/mpow2_dp.sv */
// Datapath: result and base matrices, three-stage matrix product pipeline, response register.
module mpow2_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  mpow2_pkg::dp_cmd_type   cmd,
   output mpow2_pkg::dp_stat_type  stat,
   input  mpow2_pkg::field_type    m00_in,
   input  mpow2_pkg::field_type    m01_in,
   input  mpow2_pkg::field_type    m10_in,
   input  mpow2_pkg::field_type    m11_in,
   output mpow2_pkg::field_type    r00_out,
   output mpow2_pkg::field_type    r01_out,
   output mpow2_pkg::field_type    r10_out,
   output mpow2_pkg::field_type    r11_out
);

   localparam int ENTRY_W = mpow2_pkg::ENTRY_W;
   localparam int LO_W    = mpow2_pkg::LO_W;
   localparam int HI_W    = mpow2_pkg::HI_W;
   localparam int N_ENTRY = mpow2_pkg::N_ENTRY;
   localparam int N_PROD  = mpow2_pkg::N_PROD;

   mpow2_pkg::entry_type res_ff  [N_ENTRY];
   mpow2_pkg::entry_type base_ff [N_ENTRY];
   mpow2_pkg::entry_type in_ent  [N_ENTRY];
   mpow2_pkg::entry_type opa     [N_ENTRY];
   mpow2_pkg::entry_type ent_sum [N_ENTRY];

   // Stage 1: partial products of each scalar product.
   logic [2*LO_W-1:0]    ll_ff [N_PROD];
   logic [HI_W-1:0]      lh_ff [N_PROD];
   logic [HI_W-1:0]      hl_ff [N_PROD];
   logic                 s1_valid_ff;
   mpow2_pkg::op_type    s1_op_ff;

   // Stage 2: scalar products modulo 2^ENTRY_W.
   mpow2_pkg::entry_type prod_ff [N_PROD];
   logic                 s2_valid_ff;
   mpow2_pkg::op_type    s2_op_ff;

   mpow2_pkg::field_type r_ff [N_ENTRY];

   assign in_ent[0] = m00_in[ENTRY_W-1:0];
   assign in_ent[1] = m01_in[ENTRY_W-1:0];
   assign in_ent[2] = m10_in[ENTRY_W-1:0];
   assign in_ent[3] = m11_in[ENTRY_W-1:0];

   // Left operand: result for a multiply, base for a square; right is always base.
   always_comb begin
      for (int e = 0; e < N_ENTRY; e++) begin
         opa[e] = (cmd.op == mpow2_pkg::OP_MUL) ? res_ff[e] : base_ff[e];
      end
   end

   for (genvar p = 0; p < N_PROD; p++) begin : g_lane
      localparam int I = p / 4;
      localparam int J = (p / 2) % 2;
      localparam int K = p % 2;

      mpow2_pkg::entry_type xa;
      mpow2_pkg::entry_type yb;
      logic [HI_W-1:0]      mid;

      assign xa  = opa[I*2 + K];
      assign yb  = base_ff[K*2 + J];
      assign mid = lh_ff[p] + hl_ff[p];

      always_ff @(posedge clock) begin
         ll_ff[p]   <= (2*LO_W)'(xa[LO_W-1:0]) * (2*LO_W)'(yb[LO_W-1:0]);
         lh_ff[p]   <= HI_W'(xa[LO_W-1:0] * yb[ENTRY_W-1:LO_W]);
         hl_ff[p]   <= HI_W'(xa[ENTRY_W-1:LO_W] * yb[LO_W-1:0]);
         prod_ff[p] <= ENTRY_W'(ll_ff[p]) + {mid, {LO_W{1'b0}}};
      end
   end

   always_comb begin
      for (int e = 0; e < N_ENTRY; e++) begin
         ent_sum[e] = prod_ff[2*e] + prod_ff[2*e + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_op_ff <= cmd.op;
      s2_op_ff <= s1_op_ff;
   end

   // Matrix registers: load on a new transaction, write back at the end of a product.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int e = 0; e < N_ENTRY; e++) begin
            base_ff[e] <= in_ent[e];
         end
         res_ff[0] <= ENTRY_W'(1);
         res_ff[1] <= '0;
         res_ff[2] <= '0;
         res_ff[3] <= ENTRY_W'(1);
      end else if (s2_valid_ff) begin
         if (s2_op_ff == mpow2_pkg::OP_MUL) begin
            res_ff <= ent_sum;
         end else begin
            base_ff <= ent_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         for (int e = 0; e < N_ENTRY; e++) begin
            r_ff[e] <= mpow2_pkg::sext_entry(res_ff[e]);
         end
      end
   end

   assign stat.busy = s1_valid_ff | s2_valid_ff;
   assign r00_out   = r_ff[0];
   assign r01_out   = r_ff[1];
   assign r10_out   = r_ff[2];
   assign r11_out   = r_ff[3];

   a_no_issue_on_writeback: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !s2_valid_ff)
      else $error("product issued while stage 2 still holds a product");

   a_capture_when_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !s1_valid_ff && !s2_valid_ff)
      else $error("result captured while a product is in flight");

   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !s1_valid_ff && !s2_valid_ff && !cmd.issue)
      else $error("new matrix loaded while the pipeline is active");

endmodule

/* rtl/core/mpow2_ctrl.sv */
// Controller: walks the exponent bits and sequences products through the datapath.
module mpow2_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  mpow2_pkg::exp_type      exponent,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output mpow2_pkg::dp_cmd_type   cmd,
   input  mpow2_pkg::dp_stat_type  stat
);

   localparam int EXP_W = mpow2_pkg::EXP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SQR,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   mpow2_pkg::exp_type exp_ff;
   logic               rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.op    = mpow2_pkg::OP_SQR;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_STEP: begin
            if (exp_ff != '0) begin
               cmd.issue = 1'b1;
               cmd.op    = exp_ff[0] ? mpow2_pkg::OP_MUL : mpow2_pkg::OP_SQR;
            end
         end
         ST_SQR: begin
            cmd.issue = 1'b1;
         end
         ST_WAIT: begin
         end
         ST_FINISH: begin
            cmd.capture = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  exp_ff   <= exponent;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (exp_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  exp_ff <= exp_ff >> 1;
                  // Skip the squaring once no higher bit is left.
                  if (exp_ff[0] && (exp_ff[EXP_W-1:1] != '0)) begin
                     state_ff <= ST_SQR;
                  end else begin
                     state_ff <= ST_WAIT;
                  end
               end
            end
            ST_SQR: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (!stat.busy) begin
                  state_ff <= ST_STEP;
               end
            end
            ST_FINISH: begin
               if (cmd.capture) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !stat.busy)
      else $error("controller idle while a product is in flight");

   a_mul_into_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.issue && cmd.op == mpow2_pkg::OP_MUL) |-> !stat.busy)
      else $error("multiply issued before earlier write-backs completed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !rsp_valid_ff || rsp_ready)
      else $error("response register overwritten before it was taken");

endmodule

/* test/tb_matrix_power_2x2.sv */
// Self-checking testbench for the 2x2 matrix power block.
`timescale 1ns / 100ps

module tb_matrix_power_2x2;

   typedef mpow2_pkg::field_type field_type;
   typedef mpow2_pkg::exp_type   exp_type;

   localparam int ENTRY_W = mpow2_pkg::ENTRY_W;
   localparam int EXP_W   = mpow2_pkg::EXP_W;

   // One request and one response transaction, packed the way the channels carry them.
   typedef struct packed {
      field_type m00;
      field_type m01;
      field_type m10;
      field_type m11;
      exp_type   exponent;
   } power_req_type;

   typedef struct packed {
      field_type r00;
      field_type r01;
      field_type r10;
      field_type r11;
   } power_rsp_type;

   // Working matrix at full field width; only the low ENTRY_W bits are meaningful.
   typedef struct packed {
      logic [63:0] e00;
      logic [63:0] e01;
      logic [63:0] e10;
      logic [63:0] e11;
   } mat2_type;

   localparam int    RANDOM_ITEMS = 2000;
   localparam int    IDLE_PCT     = 20;
   localparam int    DRAIN_CYCLES = 400;   // a bit over the worst-case latency
   localparam int    MAX_REPORTS  = 40;
   localparam int    CALM_FIRST   = 900;   // random items in this window run without idling
   localparam int    CALM_LAST    = 1200;
   localparam int    PAUSE_AT     = 1500;  // second hold-off until the block drains
   localparam real   TIMEOUT_NS   = 20_000_000.0;

   // Tracks the powers in flight: predicts on every accepted request, checks every response.
   class power_scoreboard;
      power_rsp_type powers_due[$];
      int unsigned   requests_seen;
      int unsigned   responses_checked;
      int unsigned   mismatches;
      int unsigned   zero_exps;
      int unsigned   long_exps;

      function new();
         requests_seen     = 0;
         responses_checked = 0;
         mismatches        = 0;
         zero_exps         = 0;
         long_exps         = 0;
      endfunction

      function logic [63:0] entry_mask();
         if (ENTRY_W >= 64) begin
            return '1;
         end
         return (64'd1 << ENTRY_W) - 64'd1;
      endfunction

      // Sign-extend an ENTRY_W-bit value to the 64-bit response field.
      function field_type widen(logic [63:0] v);
         logic [63:0] m;
         logic [63:0] w;
         m = entry_mask();
         w = v & m;
         if (ENTRY_W < 64 && w[ENTRY_W-1]) begin
            w = w | ~m;
         end
         return field_type'(w);
      endfunction

      function mat2_type mat_product(mat2_type a, mat2_type b);
         mat2_type    p;
         logic [63:0] m;
         m     = entry_mask();
         p.e00 = (a.e00 * b.e00 + a.e01 * b.e10) & m;
         p.e01 = (a.e00 * b.e01 + a.e01 * b.e11) & m;
         p.e10 = (a.e10 * b.e00 + a.e11 * b.e10) & m;
         p.e11 = (a.e10 * b.e01 + a.e11 * b.e11) & m;
         return p;
      endfunction

      // Square-and-multiply from the low exponent bit up; result starts as identity.
      function power_rsp_type matrix_power(power_req_type rq);
         mat2_type      base;
         mat2_type      acc;
         logic [63:0]   m;
         power_rsp_type r;
         m        = entry_mask();
         base.e00 = rq.m00 & m;
         base.e01 = rq.m01 & m;
         base.e10 = rq.m10 & m;
         base.e11 = rq.m11 & m;
         acc      = '{e00: 64'd1, e01: 64'd0, e10: 64'd0, e11: 64'd1};
         for (int b = 0; b < EXP_W; b++) begin
            if (rq.exponent[b]) begin
               acc = mat_product(acc, base);
            end
            base = mat_product(base, base);
         end
         r.r00 = widen(acc.e00);
         r.r01 = widen(acc.e01);
         r.r10 = widen(acc.e10);
         r.r11 = widen(acc.e11);
         return r;
      endfunction

      function void note_request(power_req_type rq);
         requests_seen++;
         if (rq.exponent == '0) begin
            zero_exps++;
         end
         if (rq.exponent[EXP_W-1]) begin
            long_exps++;
         end
         powers_due.push_back(matrix_power(rq));
      endfunction

      function void report(string what, field_type want, field_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
         end
      endfunction

      function void check_response(power_rsp_type got);
         power_rsp_type want;
         if (powers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("%0t ns: response with none expected, expected nothing, actual %h %h %h %h",
                        $time, got.r00, got.r01, got.r10, got.r11);
            end
            return;
         end
         want = powers_due.pop_front();
         responses_checked++;
         if (got.r00 !== want.r00) report("r00_out", want.r00, got.r00);
         if (got.r01 !== want.r01) report("r01_out", want.r01, got.r01);
         if (got.r10 !== want.r10) report("r10_out", want.r10, got.r10);
         if (got.r11 !== want.r11) report("r11_out", want.r11, got.r11);
      endfunction

      function int pending();
         return powers_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;    // set to drop random idling on both channels

   mpow2_req_if req_bus ();
   mpow2_rsp_if rsp_bus ();

   power_scoreboard sb = new();

   matrix_power_2x2 uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // 4 ns clock period.
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Drive every block input to a known value from time zero.
   initial begin
      reset            = 1'b1;
      calm             = 1'b0;
      req_bus.valid    = 1'b0;
      req_bus.m00_in   = '0;
      req_bus.m01_in   = '0;
      req_bus.m10_in   = '0;
      req_bus.m11_in   = '0;
      req_bus.exponent = '0;
      rsp_bus.ready    = 1'b0;
   end

   // Response side: stall about one cycle in five, except inside the calm window.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (calm) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Sample both channels at the rising edge; check the response before noting the request.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response('{r00: rsp_bus.r00_out, r01: rsp_bus.r01_out,
                                r10: rsp_bus.r10_out, r11: rsp_bus.r11_out});
         end
         if (req_bus.valid && req_bus.ready) begin
            sb.note_request('{m00: req_bus.m00_in, m01: req_bus.m01_in,
                              m10: req_bus.m10_in, m11: req_bus.m11_in,
                              exponent: req_bus.exponent});
         end
      end
   end

   // Present one request transaction; enter and leave at a falling edge.
   task automatic send_power(power_req_type rq);
      // Idle first at random; within this task the valid line only drops during such a gap.
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.m00_in   <= rq.m00;
      req_bus.m01_in   <= rq.m01;
      req_bus.m10_in   <= rq.m10;
      req_bus.m11_in   <= rq.m11;
      req_bus.exponent <= rq.exponent;
      // Hold until the handshake completes.
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding power to come back.
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (sb.pending() != 0);
   endtask

   function automatic power_req_type make_req(field_type a, field_type b, field_type c,
                                              field_type d, exp_type n);
      power_req_type rq;
      rq.m00      = a;
      rq.m01      = b;
      rq.m10      = c;
      rq.m11      = d;
      rq.exponent = n;
      return rq;
   endfunction

   function automatic field_type rand_entry();
      field_type v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = {$urandom, $urandom};
         4, 5, 6:    v = field_type'($signed($urandom_range(6)) - 3);
         7: begin
            case ($urandom_range(4))
               0:       v = '0;
               1:       v = 64'sd1;
               2:       v = -64'sd1;
               3:       v = {1'b1, 63'd0};
               default: v = {1'b0, {63{1'b1}}};
            endcase
         end
         default:    v = field_type'($signed(8'($urandom)));
      endcase
      return v;
   endfunction

   // Pick a bit length first so that short and long exponents both show up often.
   function automatic exp_type rand_exponent();
      exp_type n;
      int      len;
      n = exp_type'({$urandom, $urandom});
      if ($urandom_range(9) == 0) begin
         return n;
      end
      len = $urandom_range(EXP_W);
      if (len == 0) begin
         return '0;
      end
      if (len < EXP_W) begin
         n = n & ((exp_type'(1) << len) - exp_type'(1));
      end
      n[len-1] = 1'b1;
      return n;
   endfunction

   initial begin : stimulus
      field_type     fmin;
      field_type     fmax;
      exp_type       emax;
      exp_type       etop;
      power_req_type directed[$];

      fmin = {1'b1, 63'd0};
      fmax = {1'b0, {63{1'b1}}};
      emax = '1;
      etop = {1'b1, {(EXP_W-1){1'b0}}};

      // Hold reset, release at a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Corner matrices and exponents: zero power, wrapping products, top exponent bit.
      directed.push_back(make_req(64'sd5, -64'sd7, 64'sd11, -64'sd13, '0));
      directed.push_back(make_req('0, '0, '0, '0, '0));
      directed.push_back(make_req('0, '0, '0, '0, exp_type'(1)));
      directed.push_back(make_req(64'sd1, '0, '0, 64'sd1, emax));
      directed.push_back(make_req(fmin, fmin, fmin, fmin, exp_type'(1)));
      directed.push_back(make_req(fmin, fmin, fmin, fmin, exp_type'(2)));
      directed.push_back(make_req(fmax, fmax, fmax, fmax, exp_type'(3)));
      directed.push_back(make_req(-64'sd1, -64'sd1, -64'sd1, -64'sd1, emax));
      directed.push_back(make_req(fmax, fmin, fmin, fmax, emax));
      directed.push_back(make_req(fmin, fmax, fmax, fmin, etop));
      directed.push_back(make_req(64'sd1, 64'sd1, 64'sd1, '0, exp_type'(10)));
      directed.push_back(make_req(64'sd1, 64'sd1, 64'sd1, '0, exp_type'(90)));
      directed.push_back(make_req(64'sd1, 64'sd1, 64'sd1, '0, exp_type'(93)));
      directed.push_back(make_req(64'sd1, 64'sd1, 64'sd1, '0, emax));
      directed.push_back(make_req('0, -64'sd1, 64'sd1, '0, exp_type'(3)));
      directed.push_back(make_req(64'sd2, '0, '0, 64'sd3, exp_type'(63)));
      directed.push_back(make_req(64'sd2, '0, '0, -64'sd2, exp_type'(64)));
      directed.push_back(make_req({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, exp_type'(1)));
      directed.push_back(make_req({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom}, etop));
      directed.push_back(make_req(64'sd3, 64'sd1, -64'sd1, 64'sd3, etop - exp_type'(1)));

      foreach (directed[i]) send_power(directed[i]);

      // Let the block drain completely before the random part.
      hold_until_drained();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         calm = (k >= CALM_FIRST && k < CALM_LAST);
         if (k == PAUSE_AT) begin
            hold_until_drained();
         end
         send_power(make_req(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                             rand_exponent()));
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      // Wait for the last responses, then watch a while longer for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d powers out of %0d requests, %0d with zero exponent, %0d with bit 62 set.",
               sb.responses_checked, sb.requests_seen, sb.zero_exps, sb.long_exps);
      $display("Directed corner matrices, random entries and exponent lengths, random stalls both sides.");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Backstop against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d powers outstanding", sb.pending());
      $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
rtl/core/mpow2_pkg.sv
rtl/core/mpow2_if.sv
rtl/core/mpow2_dp.sv
rtl/core/mpow2_ctrl.sv
rtl/core/matrix_power_2x2.sv
test/tb_matrix_power_2x2.sv
